@@ rtl/bom_unicode_to_utf8_transcoder_assert.svh @@
// Assertion macros for the byte order mark transcoder.
`ifndef BOM_UNICODE_TO_UTF8_TRANSCODER_ASSERT_SVH
`define BOM_UNICODE_TO_UTF8_TRANSCODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BOMT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BOMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bomt_pkg.sv @@
// Shared types, codes and UTF-8 byte helpers for the transcoder.
`timescale 1ns / 1ps
package bomt_pkg;

  typedef logic [2:0] mode_t;

  localparam mode_t MODE_SNIFF = 3'd0;
  localparam mode_t MODE_UTF8  = 3'd1;
  localparam mode_t MODE_U16BE = 3'd2;
  localparam mode_t MODE_U16LE = 3'd3;
  localparam mode_t MODE_U32BE = 3'd4;
  localparam mode_t MODE_U32LE = 3'd5;

  localparam logic [20:0] REPL_CP = 21'h00FFFD;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       item_done;
    logic       stream_done;
  } out_t;

  typedef struct packed {
    logic [7:0] data;
    mode_t      mode;
    logic       eos;
    logic       fin;
  } token_t;

  typedef struct packed {
    logic        pre;
    logic        cpv;
    logic [20:0] cp;
    logic [1:0]  post;
    logic        eos;
    logic        fin;
  } job_t;

  function automatic logic [1:0] utf8_last(input logic [20:0] cp);
    if (cp < 21'h80) begin
      return 2'd0;
    end else if (cp < 21'h800) begin
      return 2'd1;
    end else if (cp < 21'h10000) begin
      return 2'd2;
    end
    return 2'd3;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] last,
                                           input logic [1:0] idx);
    logic [7:0] b;
    b = {2'b10, cp[5:0]};
    case (last)
      2'd0: b = {1'b0, cp[6:0]};
      2'd1: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      2'd2: begin
        case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

@@ rtl/bomt_front.sv @@
// Front end: byte order mark sniffing, held byte replay and token issue.
`timescale 1ns / 1ps
module bomt_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bomt_pkg::in_t    in_data,
  output logic             tok_valid,
  input  logic             tok_ready,
  output bomt_pkg::token_t tok
);
  import bomt_pkg::*;

  mode_t      mode_r, mode_nxt;
  logic [7:0] hdr_r [3];
  logic [1:0] hcnt_r, hcnt_nxt;
  logic       rp_v_r, rp_v_nxt;
  logic [7:0] rp_buf_r [4];
  logic [1:0] rp_idx_r, rp_idx_nxt;
  logic [1:0] rp_last_r, rp_last_nxt;
  logic       rp_fin_r, rp_fin_nxt;

  logic [7:0] c;
  logic       fin, in_fire, rp_eos;
  logic [7:0] seq [4];
  logic [2:0] n, skip;
  logic       p0, p1, p2, p3, hold;
  mode_t      dec_mode;

  assign c       = in_data.in_byte;
  assign fin     = in_data.is_final;
  assign in_ready = !rp_v_r && tok_ready;
  assign in_fire = in_valid && in_ready;
  assign rp_eos  = (rp_idx_r == rp_last_r);

  always_comb begin
    seq[0] = (hcnt_r > 2'd0) ? hdr_r[0] : c;
    seq[1] = (hcnt_r > 2'd1) ? hdr_r[1] : c;
    seq[2] = (hcnt_r > 2'd2) ? hdr_r[2] : c;
    seq[3] = c;
    n = {1'b0, hcnt_r} + 3'd1;
    p0 = (n == 3'd1) && (seq[0] == 8'hFE);
    p1 = (n < 3'd4) && (seq[0] == 8'hFF) && (n < 3'd2 || seq[1] == 8'hFE)
         && (n < 3'd3 || seq[2] == 8'h00);
    p2 = (n < 3'd3) && (seq[0] == 8'hEF) && (n < 3'd2 || seq[1] == 8'hBB);
    p3 = (n < 3'd4) && (seq[0] == 8'h00) && (n < 3'd2 || seq[1] == 8'h00)
         && (n < 3'd3 || seq[2] == 8'hFE);
    hold = !fin && (p0 || p1 || p2 || p3);
    if (n >= 3'd2 && seq[0] == 8'hFE && seq[1] == 8'hFF) begin
      dec_mode = MODE_U16BE;
      skip = 3'd2;
    end else if (n >= 3'd2 && seq[0] == 8'hFF && seq[1] == 8'hFE) begin
      if (n >= 3'd4 && seq[2] == 8'h00 && seq[3] == 8'h00) begin
        dec_mode = MODE_U32LE;
        skip = 3'd4;
      end else begin
        dec_mode = MODE_U16LE;
        skip = 3'd2;
      end
    end else if (n >= 3'd3 && seq[0] == 8'hEF && seq[1] == 8'hBB && seq[2] == 8'hBF) begin
      dec_mode = MODE_UTF8;
      skip = 3'd3;
    end else if (n >= 3'd4 && seq[0] == 8'h00 && seq[1] == 8'h00 && seq[2] == 8'hFE
                 && seq[3] == 8'hFF) begin
      dec_mode = MODE_U32BE;
      skip = 3'd4;
    end else begin
      dec_mode = MODE_UTF8;
      skip = 3'd0;
    end
  end

  always_comb begin
    if (rp_v_r) begin
      tok_valid = 1'b1;
      tok.data  = rp_buf_r[rp_idx_r];
      tok.mode  = mode_r;
      tok.eos   = rp_eos;
      tok.fin   = rp_fin_r && rp_eos;
    end else begin
      tok_valid = in_valid && (mode_r != MODE_SNIFF);
      tok.data  = c;
      tok.mode  = mode_r;
      tok.eos   = 1'b1;
      tok.fin   = fin;
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    hcnt_nxt    = hcnt_r;
    rp_v_nxt    = rp_v_r;
    rp_idx_nxt  = rp_idx_r;
    rp_last_nxt = rp_last_r;
    rp_fin_nxt  = rp_fin_r;
    if (rp_v_r) begin
      if (tok_ready) begin
        if (rp_eos) begin
          rp_v_nxt = 1'b0;
          if (rp_fin_r) begin
            mode_nxt = MODE_SNIFF;
          end
        end else begin
          rp_idx_nxt = rp_idx_r + 2'd1;
        end
      end
    end else if (in_fire) begin
      if (mode_r != MODE_SNIFF) begin
        if (fin) begin
          mode_nxt = MODE_SNIFF;
        end
      end else if (hold) begin
        hcnt_nxt = hcnt_r + 2'd1;
      end else begin
        hcnt_nxt = 2'd0;
        if (skip < n) begin
          mode_nxt    = dec_mode;
          rp_v_nxt    = 1'b1;
          rp_idx_nxt  = skip[1:0];
          rp_last_nxt = 2'(n - 3'd1);
          rp_fin_nxt  = fin;
        end else begin
          mode_nxt = fin ? MODE_SNIFF : dec_mode;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SNIFF;
      hcnt_r <= 2'd0;
      rp_v_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      hcnt_r <= hcnt_nxt;
      rp_v_r <= rp_v_nxt;
    end
    rp_idx_r  <= rp_idx_nxt;
    rp_last_r <= rp_last_nxt;
    rp_fin_r  <= rp_fin_nxt;
    if (in_fire && mode_r == MODE_SNIFF) begin
      if (hold) begin
        hdr_r[hcnt_r] <= c;
      end else begin
        rp_buf_r <= seq;
      end
    end
  end

endmodule

@@ rtl/bomt_fifo.sv @@
// Short token queue between the front end and the decoder.
`timescale 1ns / 1ps
module bomt_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  bomt_pkg::token_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output bomt_pkg::token_t pop_data
);
  import bomt_pkg::*;

  token_t         mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           push, pop;

  assign push_ready = (cnt_r != QDEPTH[QAW:0]);
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

@@ rtl/bomt_decode.sv @@
// Decoder: UTF-8, UTF-16 and UTF-32 unit assembly into code point jobs.
`timescale 1ns / 1ps
module bomt_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tok_valid,
  output logic             tok_ready,
  input  bomt_pkg::token_t tok,
  output logic             job_valid,
  input  logic             job_ready,
  output bomt_pkg::job_t   job
);
  import bomt_pkg::*;

  logic [7:0]  lead_r, lead_nxt;
  logic [1:0]  need_r, need_nxt;
  logic [1:0]  got_r, got_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic [23:0] up_r, up_nxt;
  logic [1:0]  ucnt_r, ucnt_nxt;
  logic [9:0]  hs_r, hs_nxt;
  logic        hp_r, hp_nxt;

  logic        fire;

  assign job_valid = tok_valid;
  assign tok_ready = job_ready;
  assign fire      = tok_valid && job_ready;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] u;
    logic [31:0] w;
    logic [7:0]  lo, hi;
    logic        done;
    b        = tok.data;
    u        = '0;
    w        = '0;
    lo       = 8'h80;
    hi       = 8'hBF;
    done     = 1'b0;
    job      = '0;
    job.eos  = tok.eos;
    job.fin  = tok.fin;
    lead_nxt = lead_r;
    need_nxt = need_r;
    got_nxt  = got_r;
    acc_nxt  = acc_r;
    up_nxt   = up_r;
    ucnt_nxt = ucnt_r;
    hs_nxt   = hs_r;
    hp_nxt   = hp_r;
    case (tok.mode)
      MODE_U16BE, MODE_U16LE: begin
        if (ucnt_r == 2'd1) begin
          u = (tok.mode == MODE_U16BE) ? {up_r[7:0], b} : {b, up_r[7:0]};
          up_nxt   = '0;
          ucnt_nxt = 2'd0;
          if (hp_r) begin
            hp_nxt = 1'b0;
            hs_nxt = '0;
            if (u[15:10] == 6'b110111) begin
              job.cpv = 1'b1;
              job.cp  = 21'h10000 + {1'b0, hs_r, 10'd0} + {11'd0, u[9:0]};
              done    = 1'b1;
            end else begin
              job.pre = 1'b1;
            end
          end
          if (!done) begin
            if (u[15:10] == 6'b110110) begin
              hp_nxt = 1'b1;
              hs_nxt = u[9:0];
            end else if (u[15:10] == 6'b110111) begin
              job.cpv = 1'b1;
              job.cp  = REPL_CP;
            end else begin
              job.cpv = 1'b1;
              job.cp  = {5'd0, u};
            end
          end
        end else begin
          up_nxt   = {16'd0, b};
          ucnt_nxt = 2'd1;
        end
        job.post = {1'b0, hp_nxt} + {1'b0, ucnt_nxt != 2'd0};
      end
      MODE_U32BE, MODE_U32LE: begin
        if (ucnt_r == 2'd3) begin
          w = (tok.mode == MODE_U32BE) ? {up_r, b} : {b, up_r[7:0], up_r[15:8], up_r[23:16]};
          up_nxt   = '0;
          ucnt_nxt = 2'd0;
          job.cpv  = 1'b1;
          if (w > 32'h10FFFF || (w >= 32'hD800 && w <= 32'hDFFF)) begin
            job.cp = REPL_CP;
          end else begin
            job.cp = w[20:0];
          end
        end else begin
          up_nxt   = {up_r[15:0], b};
          ucnt_nxt = ucnt_r + 2'd1;
        end
        job.post = {1'b0, ucnt_nxt != 2'd0};
      end
      default: begin
        if (need_r != 2'd0) begin
          if (got_r == 2'd0) begin
            if (lead_r == 8'hE0) begin
              lo = 8'hA0;
            end else if (lead_r == 8'hED) begin
              hi = 8'h9F;
            end else if (lead_r == 8'hF0) begin
              lo = 8'h90;
            end else if (lead_r == 8'hF4) begin
              hi = 8'h8F;
            end
          end
          if (b >= lo && b <= hi) begin
            done    = 1'b1;
            acc_nxt = {acc_r[14:0], b[5:0]};
            got_nxt = got_r + 2'd1;
            if ({1'b0, got_r} + 3'd1 >= {1'b0, need_r}) begin
              job.cpv  = 1'b1;
              job.cp   = {acc_r[14:0], b[5:0]};
              lead_nxt = '0;
              need_nxt = '0;
              got_nxt  = '0;
              acc_nxt  = '0;
            end
          end else begin
            job.pre  = 1'b1;
            lead_nxt = '0;
            need_nxt = '0;
            got_nxt  = '0;
            acc_nxt  = '0;
          end
        end
        if (!done) begin
          if (b < 8'h80) begin
            job.cpv = 1'b1;
            job.cp  = {13'd0, b};
          end else if (b >= 8'hC2 && b <= 8'hDF) begin
            lead_nxt = b;
            need_nxt = 2'd1;
            acc_nxt  = {16'd0, b[4:0]};
          end else if (b >= 8'hE0 && b <= 8'hEF) begin
            lead_nxt = b;
            need_nxt = 2'd2;
            acc_nxt  = {17'd0, b[3:0]};
          end else if (b >= 8'hF0 && b <= 8'hF4) begin
            lead_nxt = b;
            need_nxt = 2'd3;
            acc_nxt  = {18'd0, b[2:0]};
          end else begin
            job.cpv = 1'b1;
            job.cp  = REPL_CP;
          end
        end
        job.post = {1'b0, need_nxt != 2'd0};
      end
    endcase
    if (!tok.fin) begin
      job.post = 2'd0;
    end else begin
      lead_nxt = '0;
      need_nxt = '0;
      got_nxt  = '0;
      acc_nxt  = '0;
      up_nxt   = '0;
      ucnt_nxt = '0;
      hs_nxt   = '0;
      hp_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= '0;
      need_r <= '0;
      got_r  <= '0;
      acc_r  <= '0;
      up_r   <= '0;
      ucnt_r <= '0;
      hs_r   <= '0;
      hp_r   <= 1'b0;
    end else if (fire) begin
      lead_r <= lead_nxt;
      need_r <= need_nxt;
      got_r  <= got_nxt;
      acc_r  <= acc_nxt;
      up_r   <= up_nxt;
      ucnt_r <= ucnt_nxt;
      hs_r   <= hs_nxt;
      hp_r   <= hp_nxt;
    end
  end

endmodule

@@ rtl/bomt_emit.sv @@
// Back end: code point jobs to UTF-8 beats, with step end marking.
`timescale 1ns / 1ps
module bomt_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  output logic           job_ready,
  input  bomt_pkg::job_t job,
  output logic           out_valid,
  input  logic           out_ready,
  output bomt_pkg::out_t out_data
);
  import bomt_pkg::*;

  typedef enum logic [1:0] {PH_PRE, PH_CP, PH_POST, PH_END} phase_t;

  phase_t     ph_r, ph_nxt, seg_ph;
  logic       job_v_r, job_v_nxt;
  job_t       job_r, job_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [1:0] post_r, post_nxt;
  logic       pend_v_r, pend_v_nxt;
  logic       pend_res_r, pend_res_nxt;
  out_t       pend_r, pend_nxt;
  logic       out_v_r, out_v_nxt;
  out_t       out_r, out_nxt;

  logic [1:0] cp_last;
  logic [7:0] gbyte;
  logic       gen_v, seg_last, g_last, out_free, pend_move, gen_acc, job_finish;

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    cp_last  = utf8_last(job_r.cp);
    gen_v    = job_v_r && (ph_r != PH_END);
    gbyte    = 8'hEF;
    seg_last = 1'b0;
    seg_ph   = PH_END;
    case (ph_r)
      PH_PRE: begin
        seg_last = (idx_r == 2'd2);
        if (job_r.cpv) begin
          seg_ph = PH_CP;
        end else if (post_r != 2'd0) begin
          seg_ph = PH_POST;
        end
      end
      PH_CP: begin
        gbyte    = utf8_byte(job_r.cp, cp_last, idx_r);
        seg_last = (idx_r == cp_last);
        if (post_r != 2'd0) begin
          seg_ph = PH_POST;
        end
      end
      PH_POST: begin
        seg_last = (idx_r == 2'd2);
        if (post_r != 2'd1) begin
          seg_ph = PH_POST;
        end
      end
      default: seg_last = 1'b0;
    endcase
    if (ph_r == PH_PRE || ph_r == PH_POST) begin
      case (idx_r)
        2'd0:    gbyte = 8'hEF;
        2'd1:    gbyte = 8'hBF;
        default: gbyte = 8'hBD;
      endcase
    end
    g_last     = seg_last && (seg_ph == PH_END);
    out_free   = !out_v_r || out_ready;
    pend_move  = pend_v_r && out_free && (pend_res_r || gen_v);
    gen_acc    = gen_v && (!pend_v_r || pend_move);
    job_finish = job_v_r && ((ph_r == PH_END) || (gen_acc && g_last));
    job_ready  = !job_v_r || job_finish;
  end

  always_comb begin
    ph_nxt       = ph_r;
    job_v_nxt    = job_v_r;
    job_nxt      = job_r;
    idx_nxt      = idx_r;
    post_nxt     = post_r;
    pend_v_nxt   = pend_v_r;
    pend_res_nxt = pend_res_r;
    pend_nxt     = pend_r;
    out_v_nxt    = out_v_r;
    out_nxt      = out_r;
    if (gen_acc) begin
      if (seg_last) begin
        ph_nxt  = seg_ph;
        idx_nxt = 2'd0;
        if (ph_r == PH_POST) begin
          post_nxt = post_r - 2'd1;
        end
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
    if (job_finish) begin
      job_v_nxt = 1'b0;
    end
    if (job_valid && job_ready) begin
      job_v_nxt = 1'b1;
      job_nxt   = job;
      idx_nxt   = 2'd0;
      post_nxt  = job.post;
      if (job.pre) begin
        ph_nxt = PH_PRE;
      end else if (job.cpv) begin
        ph_nxt = PH_CP;
      end else if (job.post != 2'd0) begin
        ph_nxt = PH_POST;
      end else begin
        ph_nxt = PH_END;
      end
    end
    if (gen_acc) begin
      pend_v_nxt           = 1'b1;
      pend_nxt.out_byte    = gbyte;
      pend_nxt.item_done   = g_last && job_r.eos;
      pend_nxt.stream_done = g_last && job_r.eos && job_r.fin;
      pend_res_nxt         = !g_last || job_r.eos;
    end else if (pend_move) begin
      pend_v_nxt = 1'b0;
    end else if (job_v_r && ph_r == PH_END && job_r.eos && pend_v_r && !pend_res_r) begin
      pend_res_nxt         = 1'b1;
      pend_nxt.item_done   = 1'b1;
      pend_nxt.stream_done = job_r.fin;
    end
    if (pend_move) begin
      out_v_nxt = 1'b1;
      out_nxt   = pend_r;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r       <= PH_END;
      job_v_r    <= 1'b0;
      pend_v_r   <= 1'b0;
      pend_res_r <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      ph_r       <= ph_nxt;
      job_v_r    <= job_v_nxt;
      pend_v_r   <= pend_v_nxt;
      pend_res_r <= pend_res_nxt;
      out_v_r    <= out_v_nxt;
    end
    job_r  <= job_nxt;
    idx_r  <= idx_nxt;
    post_r <= post_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

endmodule

@@ rtl/bom_unicode_to_utf8_transcoder.sv @@
// Top level of the byte order mark sniffing transcoder to UTF-8.
// The first output beat of an input beat passes the queue, job, pending and output registers.
// Throughput: one input beat per cycle while each byte gives at most one output beat;
// the output runs one beat per cycle while out_ready holds, so expansion sets the input rate.
// A mark decision replays the held bytes one per cycle when the queue has room; input waits.
// Synchronous active-low reset empties the queue and returns to byte order mark sniffing.
`timescale 1ns / 1ps
`include "bom_unicode_to_utf8_transcoder_assert.svh"
module bom_unicode_to_utf8_transcoder (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bomt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output bomt_pkg::out_t out_data
);
  import bomt_pkg::*;

  logic   tok_valid, tok_ready, q_valid, q_ready, job_valid, job_ready;
  token_t tok, q_tok;
  job_t   job;

  bomt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok)
  );

  bomt_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (tok_valid),
    .push_ready (tok_ready),
    .push_data  (tok),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_tok)
  );

  bomt_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (q_valid),
    .tok_ready (q_ready),
    .tok       (q_tok),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  bomt_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `BOMT_ASSERT_NOW(a_stream_end_marks_item, out_valid && out_data.stream_done, out_data.item_done, "stream end without item end")
  `BOMT_ASSERT_NOW(a_fin_on_step_end, q_valid && q_tok.fin, q_tok.eos, "final token not at step end")
  `BOMT_ASSERT_NEXT(a_token_held, tok_valid && !tok_ready, tok_valid, "token dropped while queue full")

endmodule

@@ bench/bom_transcoder_checker.sv @@
// Checker that predicts the transcoder's UTF-8 output beats and compares them.
`timescale 1ns / 1ps
module bom_transcoder_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  bomt_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  bomt_pkg::out_t out_data,
  output int             fail_count,
  output int             pending_bytes
);
  import bomt_pkg::*;

  mode_t       enc_mode;
  logic [7:0]  held [3];
  int          held_n;
  logic [7:0]  lead;
  int          need;
  int          got;
  logic [20:0] accum;
  logic [23:0] partial;
  int          part_n;
  logic [9:0]  hi_sur;
  logic        hi_held;
  logic [7:0]  step_bytes [$];
  out_t        utf8_queue [$];

  assign pending_bytes = utf8_queue.size();

  task automatic clear_state();
    enc_mode = MODE_SNIFF;
    held_n = 0;
    lead = 0;
    need = 0;
    got = 0;
    accum = 0;
    partial = 0;
    part_n = 0;
    hi_sur = 0;
    hi_held = 0;
  endtask

  task automatic put_code(input logic [31:0] cp);
    cp = cp & 32'h1FFFFF;
    if (cp < 32'h80) begin
      step_bytes.push_back(cp[7:0]);
    end else if (cp < 32'h800) begin
      step_bytes.push_back(8'hC0 | cp[10:6]);
      step_bytes.push_back(8'h80 | cp[5:0]);
    end else if (cp < 32'h10000) begin
      step_bytes.push_back(8'hE0 | cp[15:12]);
      step_bytes.push_back(8'h80 | cp[11:6]);
      step_bytes.push_back(8'h80 | cp[5:0]);
    end else begin
      step_bytes.push_back(8'hF0 | cp[20:18]);
      step_bytes.push_back(8'h80 | cp[17:12]);
      step_bytes.push_back(8'h80 | cp[11:6]);
      step_bytes.push_back(8'h80 | cp[5:0]);
    end
  endtask

  task automatic drop_seq();
    lead = 0;
    need = 0;
    got = 0;
    accum = 0;
  endtask

  task automatic utf8_byte_in(input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h80;
    hi = 8'hBF;
    if (need != 0) begin
      if (got == 0) begin
        if (lead == 8'hE0) lo = 8'hA0;
        else if (lead == 8'hED) hi = 8'h9F;
        else if (lead == 8'hF0) lo = 8'h90;
        else if (lead == 8'hF4) hi = 8'h8F;
      end
      if (b >= lo && b <= hi) begin
        accum = {accum[14:0], b[5:0]};
        got++;
        if (got >= need) begin
          put_code({11'd0, accum});
          drop_seq();
        end
        return;
      end
      put_code({11'd0, REPL_CP});
      drop_seq();
    end
    if (b < 8'h80) begin
      step_bytes.push_back(b);
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      lead = b; need = 1; accum = {16'd0, b[4:0]};
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      lead = b; need = 2; accum = {17'd0, b[3:0]};
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      lead = b; need = 3; accum = {18'd0, b[2:0]};
    end else begin
      put_code({11'd0, REPL_CP});
    end
  endtask

  task automatic utf16_unit(input logic [15:0] u);
    if (hi_held) begin
      hi_held = 0;
      if (u >= 16'hDC00 && u <= 16'hDFFF) begin
        put_code(32'h10000 + (32'(hi_sur) << 10) + (32'(u) - 32'hDC00));
        hi_sur = 0;
        return;
      end
      hi_sur = 0;
      put_code({11'd0, REPL_CP});
    end
    if (u >= 16'hD800 && u <= 16'hDBFF) begin
      hi_held = 1;
      hi_sur = u[9:0];
    end else if (u >= 16'hDC00 && u <= 16'hDFFF) begin
      put_code({11'd0, REPL_CP});
    end else begin
      put_code({16'd0, u});
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [31:0] cp;
    case (enc_mode)
      MODE_U16BE, MODE_U16LE: begin
        if (part_n == 1) begin
          part_n = 0;
          if (enc_mode == MODE_U16BE) utf16_unit({partial[7:0], b});
          else utf16_unit({b, partial[7:0]});
          partial = 0;
        end else begin
          partial = {16'd0, b};
          part_n = 1;
        end
      end
      MODE_U32BE, MODE_U32LE: begin
        if (part_n == 3) begin
          if (enc_mode == MODE_U32BE) cp = {partial, b};
          else cp = {b, partial[7:0], partial[15:8], partial[23:16]};
          partial = 0;
          part_n = 0;
          if (cp > 32'h10FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF)) put_code({11'd0, REPL_CP});
          else put_code(cp);
        end else begin
          partial = {partial[15:0], b};
          part_n++;
        end
      end
      default: utf8_byte_in(b);
    endcase
  endtask

  function automatic bit is_mark_prefix(input logic [7:0] s [4], input int n);
    logic [7:0] marks [4][4];
    int         lens [4];
    bit         same;
    marks = '{'{8'hFE, 8'hFF, 8'h00, 8'h00}, '{8'hFF, 8'hFE, 8'h00, 8'h00},
              '{8'hEF, 8'hBB, 8'hBF, 8'h00}, '{8'h00, 8'h00, 8'hFE, 8'hFF}};
    lens = '{2, 4, 3, 4};
    for (int k = 0; k < 4; k++) begin
      if (n < lens[k]) begin
        same = 1;
        for (int j = 0; j < n; j++) if (s[j] != marks[k][j]) same = 0;
        if (same) return 1;
      end
    end
    return 0;
  endfunction

  task automatic sniff_byte(input logic [7:0] c, input bit fin);
    logic [7:0] s [4];
    int         n;
    int         skip;
    n = held_n;
    for (int k = 0; k < n; k++) s[k] = held[k];
    s[n] = c;
    n++;
    for (int k = n; k < 4; k++) s[k] = 0;
    if (!fin && is_mark_prefix(s, n)) begin
      if (held_n < 3) begin
        held[held_n] = c;
        held_n++;
      end
      return;
    end
    if (n >= 2 && s[0] == 8'hFE && s[1] == 8'hFF) begin
      enc_mode = MODE_U16BE; skip = 2;
    end else if (n >= 2 && s[0] == 8'hFF && s[1] == 8'hFE) begin
      if (n >= 4 && s[2] == 0 && s[3] == 0) begin
        enc_mode = MODE_U32LE; skip = 4;
      end else begin
        enc_mode = MODE_U16LE; skip = 2;
      end
    end else if (n >= 3 && s[0] == 8'hEF && s[1] == 8'hBB && s[2] == 8'hBF) begin
      enc_mode = MODE_UTF8; skip = 3;
    end else if (n >= 4 && s[0] == 0 && s[1] == 0 && s[2] == 8'hFE && s[3] == 8'hFF) begin
      enc_mode = MODE_U32BE; skip = 4;
    end else begin
      enc_mode = MODE_UTF8; skip = 0;
    end
    held_n = 0;
    for (int k = skip; k < n; k++) decode_byte(s[k]);
  endtask

  task automatic predict_beat(input in_t beat);
    out_t o;
    step_bytes.delete();
    if (enc_mode == MODE_SNIFF) sniff_byte(beat.in_byte, beat.is_final);
    else decode_byte(beat.in_byte);
    if (beat.is_final) begin
      case (enc_mode)
        MODE_U16BE, MODE_U16LE: begin
          if (hi_held) put_code({11'd0, REPL_CP});
          if (part_n != 0) put_code({11'd0, REPL_CP});
        end
        MODE_U32BE, MODE_U32LE: if (part_n != 0) put_code({11'd0, REPL_CP});
        default: if (need != 0) put_code({11'd0, REPL_CP});
      endcase
    end
    for (int k = 0; k < step_bytes.size(); k++) begin
      o.out_byte = step_bytes[k];
      o.item_done = (k == step_bytes.size() - 1);
      o.stream_done = o.item_done && beat.is_final;
      utf8_queue.push_back(o);
    end
    if (beat.is_final) clear_state();
  endtask

  task automatic report(input string what, input logic [7:0] got_v, input logic [7:0] exp_v);
    $display("mismatch at %0t: %s got %02h expected %02h", $realtime, what, got_v, exp_v);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    clear_state();
  end

  always @(posedge clk) begin
    out_t e;
    if (!rst_n) begin
      clear_state();
      utf8_queue.delete();
    end else begin
      if (in_valid && in_ready) predict_beat(in_data);
      if (out_valid && out_ready) begin
        if (utf8_queue.size() == 0) begin
          report("unexpected beat", out_data.out_byte, 8'h00);
        end else begin
          e = utf8_queue.pop_front();
          if (out_data.out_byte != e.out_byte)
            report("out_byte", out_data.out_byte, e.out_byte);
          if (out_data.item_done != e.item_done)
            report("item_done", {7'd0, out_data.item_done}, {7'd0, e.item_done});
          if (out_data.stream_done != e.stream_done)
            report("stream_done", {7'd0, out_data.stream_done}, {7'd0, e.stream_done});
        end
      end
    end
  end
endmodule

@@ bench/bom_unicode_to_utf8_transcoder_tb.sv @@
// Testbench top that drives byte streams into the transcoder and gives the verdict.
`timescale 1ns / 1ps
module bom_unicode_to_utf8_transcoder_tb;
  import bomt_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  int   fail_count;
  int   pending_bytes;
  int   cycle_count;
  bit   hold_off;
  bit   sink_enable;

  bom_unicode_to_utf8_transcoder u_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  bom_transcoder_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_bytes(pending_bytes)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit fin);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{in_byte: b, is_final: fin};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_input();
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_stream(input logic [7:0] s [$]);
    for (int k = 0; k < s.size(); k++) send_byte(s[k], k == s.size() - 1);
  endtask

  function automatic logic [7:0] rand_byte(input int style);
    case (style)
      0: return 8'($urandom_range(0, 8'h7F));
      1: return 8'($urandom_range(8'h80, 8'hBF));
      2: return 8'($urandom_range(8'hC0, 8'hFF));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_stream(output int count);
    logic [7:0] s [$];
    int         kind;
    int         len;
    logic [31:0] cp;
    kind = $urandom_range(0, 9);
    len = $urandom_range(0, 6);
    case (kind)
      0: s = '{8'hEF, 8'hBB, 8'hBF};
      1, 2: s = '{8'hFE, 8'hFF};
      3, 4: s = '{8'hFF, 8'hFE};
      5: s = '{8'hFF, 8'hFE, 8'h00, 8'h00};
      6: s = '{8'h00, 8'h00, 8'hFE, 8'hFF};
      default: s = {};
    endcase
    for (int k = 0; k < len; k++) begin
      case (kind)
        1, 2, 3, 4: begin
          if ($urandom_range(0, 3) == 0) cp = $urandom_range(16'hD800, 16'hDFFF);
          else cp = $urandom_range(0, 16'hFFFF);
          if (kind <= 2) begin s.push_back(cp[15:8]); s.push_back(cp[7:0]); end
          else begin s.push_back(cp[7:0]); s.push_back(cp[15:8]); end
        end
        5, 6: begin
          cp = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h10FFFF);
          if (kind == 6) begin
            s.push_back(cp[31:24]); s.push_back(cp[23:16]);
            s.push_back(cp[15:8]); s.push_back(cp[7:0]);
          end else begin
            s.push_back(cp[7:0]); s.push_back(cp[15:8]);
            s.push_back(cp[23:16]); s.push_back(cp[31:24]);
          end
        end
        default: begin
          cp = $urandom_range(0, 32'h10FFFF);
          if ($urandom_range(0, 2) == 0) begin
            s.push_back(rand_byte($urandom_range(0, 3)));
          end else if (cp < 32'h80) begin
            s.push_back(cp[7:0]);
          end else if (cp < 32'h800) begin
            s.push_back(8'hC0 | cp[10:6]); s.push_back(8'h80 | cp[5:0]);
          end else if (cp < 32'h10000) begin
            s.push_back(8'hE0 | cp[15:12]); s.push_back(8'h80 | cp[11:6]);
            s.push_back(8'h80 | cp[5:0]);
          end else begin
            s.push_back(8'hF0 | cp[20:18]); s.push_back(8'h80 | cp[17:12]);
            s.push_back(8'h80 | cp[11:6]); s.push_back(8'h80 | cp[5:0]);
          end
        end
      endcase
    end
    if ($urandom_range(0, 4) == 0) s.push_back(rand_byte(3));
    if (s.size() == 0) s.push_back(rand_byte(3));
    count = s.size();
    send_stream(s);
  endtask

  initial begin
    int gap;
    out_ready = 0;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end else if (!sink_enable) begin
        out_ready <= 1;
        @(posedge clk);
      end else begin
        gap = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
          out_ready <= 0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end
    end
  end

  initial begin
    int sent;
    int len;
    bit paused;
    hold_off = 0;
    sink_enable = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_stream('{8'hEF, 8'hBB, 8'hBF, 8'h41, 8'hE2, 8'h82, 8'hAC});
    send_stream('{8'hFE, 8'hFF, 8'hD8, 8'h3D, 8'hDE, 8'h00, 8'hD8, 8'h00, 8'h00, 8'h41,
                  8'hDC, 8'h00, 8'hD8});
    send_stream('{8'hFF, 8'hFE, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h10, 8'h00, 8'h00, 8'hD8});
    send_stream('{8'h00, 8'h00, 8'hFE, 8'hFF, 8'h00, 8'h11, 8'h00, 8'h00, 8'h00});
    send_stream('{8'hFF, 8'hFE, 8'h41});
    send_stream('{8'hE0, 8'h80, 8'hED, 8'hA0, 8'hF4, 8'h90, 8'hF0, 8'h80, 8'hC0, 8'hFF});
    send_stream('{8'h00, 8'h00, 8'h00});
    send_stream('{8'hEF, 8'hBB});
    send_stream('{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hC2});
    send_byte(8'hFE, 1);
    idle_input();
    wait (pending_bytes == 0);
    sink_enable = 1;
    hold_off = 1;
    sent = 0;
    paused = 0;
    while (sent < 285) begin
      random_stream(len);
      sent += len;
      if (!paused && sent >= 140) begin
        paused = 1;
        idle_input();
        wait (pending_bytes == 0);
        @(posedge clk);
      end
    end
    idle_input();
    while (pending_bytes != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
